@@ src/assert_macros.svh @@
// Concurrent assertion macros for the LWE bit decrypt block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define LBDP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lbdp assertion failed");

`define LBDP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lbdp assertion failed");

`else

`define LBDP_ASSERT(label, clk, rst_n, prop)

`define LBDP_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

@@ src/lbdp_pkg.sv @@
package lbdp_pkg;

    localparam int MODULUS    = 251;
    localparam int KEY_LENGTH = 8;
    localparam int COEF_W     = 8;
    localparam int PROD_W     = 2 * COEF_W;
    localparam int SUM_MAX    = KEY_LENGTH * (2**COEF_W - 1) * (2**COEF_W - 1);
    localparam int SUM_W      = $clog2(SUM_MAX + 1);
    localparam int HALF       = MODULUS / 2;
    localparam int FOLD       = 2**COEF_W - MODULUS;
    localparam int FOLD1_MAX  = ((2**SUM_W - 1) >> COEF_W) * FOLD + (2**COEF_W - 1);
    localparam int FOLD1_W    = $clog2(FOLD1_MAX + 1);
    localparam int FOLD2_MAX  = ((2**FOLD1_W - 1) >> COEF_W) * FOLD + (2**COEF_W - 1);
    localparam int FOLD2_W    = $clog2(FOLD2_MAX + 1);
    localparam int KEY_W      = 8 * COEF_W;
    localparam int IN_DATA_W  = (KEY_LENGTH + 1) * COEF_W;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = $clog2(BYTE_W);
    localparam int PART_W     = BYTE_W - 1;

    typedef struct packed {
        logic valid;
        logic start;
    } pipe_ctl_t;

    typedef logic [KEY_LENGTH-1:0][COEF_W-1:0] coef_vec_t;

endpackage

@@ src/lbdp_dot.sv @@
module lbdp_dot
    import lbdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  pipe_ctl_t          in_ctl,
    input  coef_vec_t          mask,
    input  logic [COEF_W-1:0]  body,
    input  logic [KEY_W-1:0]   secret_key,
    output pipe_ctl_t          sum_ctl,
    output logic [SUM_W-1:0]   sum,
    output logic [COEF_W-1:0]  sum_body
);

    pipe_ctl_t                              prod_ctl_reg;
    logic [KEY_LENGTH-1:0][PROD_W-1:0]      prod_reg;
    logic [KEY_LENGTH-1:0][PROD_W-1:0]      prod_next;
    logic [COEF_W-1:0]                      prod_body_reg;
    pipe_ctl_t                              sum_ctl_reg;
    logic [SUM_W-1:0]                       sum_reg;
    logic [SUM_W-1:0]                       sum_next;
    logic [COEF_W-1:0]                      sum_body_reg;

    always_comb
    begin
        for (int j = 0; j < KEY_LENGTH; j++)
        begin
            prod_next[j] = PROD_W'(mask[j]) * PROD_W'(secret_key[j*COEF_W +: COEF_W]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int j = 0; j < KEY_LENGTH; j++)
        begin
            sum_next = sum_next + SUM_W'(prod_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_ctl_reg <= '0;
            sum_ctl_reg  <= '0;
        end
        else if (advance)
        begin
            prod_ctl_reg <= in_ctl;
            sum_ctl_reg  <= prod_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg      <= prod_next;
            prod_body_reg <= body;
            sum_reg       <= sum_next;
            sum_body_reg  <= prod_body_reg;
        end
    end

    assign sum_ctl  = sum_ctl_reg;
    assign sum      = sum_reg;
    assign sum_body = sum_body_reg;

endmodule

@@ src/lbdp_reduce.sv @@
`include "assert_macros.svh"

module lbdp_reduce
    import lbdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  pipe_ctl_t          sum_ctl,
    input  logic [SUM_W-1:0]   sum,
    input  logic [COEF_W-1:0]  sum_body,
    output pipe_ctl_t          red_ctl,
    output logic [COEF_W-1:0]  acc,
    output logic [COEF_W-1:0]  red_body
);

    pipe_ctl_t            red_ctl_reg;
    logic [COEF_W-1:0]    acc_reg;
    logic [COEF_W-1:0]    acc_next;
    logic [COEF_W-1:0]    body_reg;
    logic [COEF_W-1:0]    body_next;
    logic [FOLD1_W-1:0]   fold1;
    logic [FOLD2_W-1:0]   fold2;

    // fold the bits above the low byte back in: 2^8 is congruent to FOLD
    always_comb
    begin
        fold1 = FOLD1_W'(sum[SUM_W-1:COEF_W]) * FOLD1_W'(FOLD)
              + FOLD1_W'(sum[COEF_W-1:0]);
        fold2 = FOLD2_W'(fold1[FOLD1_W-1:COEF_W]) * FOLD2_W'(FOLD)
              + FOLD2_W'(fold1[COEF_W-1:0]);
        if (fold2 >= FOLD2_W'(MODULUS))
        begin
            acc_next = COEF_W'(fold2 - FOLD2_W'(MODULUS));
        end
        else
        begin
            acc_next = COEF_W'(fold2);
        end
        if (sum_body >= COEF_W'(MODULUS))
        begin
            body_next = sum_body - COEF_W'(MODULUS);
        end
        else
        begin
            body_next = sum_body;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_ctl_reg <= '0;
        end
        else if (advance)
        begin
            red_ctl_reg <= sum_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg  <= acc_next;
            body_reg <= body_next;
        end
    end

    assign red_ctl  = red_ctl_reg;
    assign acc      = acc_reg;
    assign red_body = body_reg;

    `LBDP_ASSERT(a_residue_range, clk, rst_n,
        red_ctl_reg.valid |-> (acc_reg < COEF_W'(MODULUS) && body_reg < COEF_W'(MODULUS)))

endmodule

@@ src/lbdp_pack.sv @@
`include "assert_macros.svh"

module lbdp_pack
    import lbdp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               out_ready,
    input  pipe_ctl_t          red_ctl,
    input  logic [COEF_W-1:0]  acc,
    input  logic [COEF_W-1:0]  red_body,
    output logic               out_valid,
    output logic [BYTE_W-1:0]  out_byte
);

    logic [PART_W-1:0]  partial_reg;
    logic [PART_W-1:0]  partial_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic [BYTE_W-1:0]  out_byte_next;
    logic [COEF_W:0]    d_sum;
    logic [COEF_W-1:0]  d;
    logic [COEF_W-1:0]  mirror;
    logic [COEF_W-1:0]  dist0;
    logic [COEF_W-1:0]  dist1;
    logic               bit_val;
    logic [PART_W-1:0]  part_eff;
    logic [CNT_W-1:0]   cnt_eff;

    always_comb
    begin
        d_sum = (COEF_W+1)'(red_body) + (COEF_W+1)'(MODULUS) - (COEF_W+1)'(acc);
        if (d_sum >= (COEF_W+1)'(MODULUS))
        begin
            d = COEF_W'(d_sum - (COEF_W+1)'(MODULUS));
        end
        else
        begin
            d = COEF_W'(d_sum);
        end
        mirror = COEF_W'(MODULUS) - d;
        dist0  = (d < mirror) ? d : mirror;
        dist1  = (d >= COEF_W'(HALF)) ? d - COEF_W'(HALF) : COEF_W'(HALF) - d;
        bit_val = dist1 < dist0;
    end

    always_comb
    begin
        partial_next   = partial_reg;
        count_next     = count_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !out_ready;
        part_eff       = red_ctl.start ? '0 : partial_reg;
        cnt_eff        = red_ctl.start ? '0 : count_reg;
        if (advance && red_ctl.valid)
        begin
            if (cnt_eff == CNT_W'(BYTE_W - 1))
            begin
                out_byte_next  = {part_eff, bit_val};
                out_valid_next = 1'b1;
                partial_next   = '0;
                count_next     = '0;
            end
            else
            begin
                partial_next = {part_eff[PART_W-2:0], bit_val};
                count_next   = cnt_eff + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg   <= partial_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    `LBDP_ASSERT(a_emit_clears_count, clk, rst_n,
        $rose(out_valid_reg) |-> (count_reg == '0 && partial_reg == '0))

    `LBDP_ASSERT_NEXT(a_stall_holds_state, clk, rst_n, !advance,
        $stable(partial_reg) && $stable(count_reg))

endmodule

@@ src/lwe_bit_decrypt_byte_pack_unit.sv @@
// Channel     Direction  tdata                                  tuser
// s_axis      in         mask_0..mask_7, body (8 bits each)     message_start
// m_axis      out        plain_byte                             -
// cfg         in         secret_key (64 bits, write only)       -
//
// One request per cycle is accepted while the pipeline advances; a byte leaves after
// every eighth request. Its accepting edge loads the input register; the product, sum,
// reduce and output registers follow, and the byte is valid from the output register.
// All stages advance together, gated by the output register being free or taken.
// Reset clears the key, the partial byte, and all valid flags.
module lwe_bit_decrypt_byte_pack_unit
    import lbdp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // mask_0 .. mask_7, body
    input  logic                  s_axis_tuser,   // message_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [BYTE_W-1:0]     m_axis_tdata,   // plain_byte
    input  logic                  cfg_we,
    input  logic [KEY_W-1:0]      cfg_wdata
);

    logic                 advance;
    logic [KEY_W-1:0]     key_reg;
    pipe_ctl_t            in_ctl_reg;
    coef_vec_t            mask_reg;
    logic [COEF_W-1:0]    body_reg;
    pipe_ctl_t            sum_ctl;
    logic [SUM_W-1:0]     sum;
    logic [COEF_W-1:0]    sum_body;
    pipe_ctl_t            red_ctl;
    logic [COEF_W-1:0]    acc;
    logic [COEF_W-1:0]    red_body;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            in_ctl_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                key_reg <= cfg_wdata;
            end
            if (advance)
            begin
                in_ctl_reg.valid <= s_axis_tvalid;
                in_ctl_reg.start <= s_axis_tuser;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int j = 0; j < KEY_LENGTH; j++)
            begin
                mask_reg[j] <= s_axis_tdata[j*COEF_W +: COEF_W];
            end
            body_reg <= s_axis_tdata[KEY_LENGTH*COEF_W +: COEF_W];
        end
    end

    lbdp_dot u_dot (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_ctl     (in_ctl_reg),
        .mask       (mask_reg),
        .body       (body_reg),
        .secret_key (key_reg),
        .sum_ctl    (sum_ctl),
        .sum        (sum),
        .sum_body   (sum_body)
    );

    lbdp_reduce u_reduce (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .sum_ctl  (sum_ctl),
        .sum      (sum),
        .sum_body (sum_body),
        .red_ctl  (red_ctl),
        .acc      (acc),
        .red_body (red_body)
    );

    lbdp_pack u_pack (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .out_ready (m_axis_tready),
        .red_ctl   (red_ctl),
        .acc       (acc),
        .red_body  (red_body),
        .out_valid (m_axis_tvalid),
        .out_byte  (m_axis_tdata)
    );

endmodule

@@ dv/lwe_bit_decrypt_byte_pack_unit_tb.sv @@
module lwe_bit_decrypt_byte_pack_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbdp_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int N_ROWS = 25;
    localparam int PHASE_ITEMS = 105;
    localparam int N_PHASES = 6;
    localparam logic [KEY_W-1:0] ONES = '1;

    typedef struct packed {
        logic              load_key;
        logic [KEY_W-1:0]  key;
        coef_vec_t         masks;
        logic [COEF_W-1:0] body;
        logic              start;
        logic              typed;
        logic [BYTE_W-1:0] want;
    } cipher_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata;   // mask_0 .. mask_7, body
    logic                 s_axis_tuser;   // message_start
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [BYTE_W-1:0]    m_axis_tdata;   // plain_byte
    logic                 cfg_we;
    logic [KEY_W-1:0]     cfg_wdata;

    logic [BYTE_W-1:0]    byte_q[$];
    logic [KEY_W-1:0]     key_now;
    logic [PART_W-1:0]    held_bits;
    logic [CNT_W-1:0]     held_count;
    cipher_row_t          cipher_rows [N_ROWS];
    bit                   idle_on = 1'b1;
    int                   err_count = 0;
    int                   quiet_cycles = 0;

    lwe_bit_decrypt_byte_pack_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    always #5ns clk = ~clk;

    function automatic logic decode_cipher_bit(coef_vec_t masks, logic [COEF_W-1:0] body,
                                               logic [KEY_W-1:0] key);
        int unsigned acc;
        int unsigned d;
        int unsigned to_zero;
        int unsigned to_half;
        acc = 0;
        for (int j = 0; j < KEY_LENGTH; j++)
            acc += 32'(masks[j]) * 32'(key[j*COEF_W +: COEF_W]);
        acc = acc % MODULUS;
        d = (32'(body) % MODULUS + MODULUS - acc) % MODULUS;
        to_zero = (d < MODULUS - d) ? d : MODULUS - d;
        to_half = (d >= HALF) ? d - HALF : HALF - d;
        return to_half < to_zero;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd250;
            3: return 8'd251;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(string what, logic [BYTE_W-1:0] got,
                                   logic [BYTE_W-1:0] want);
        $display("%0t: mismatch, %s: got %02h expected %02h", $realtime, what, got, want);
        err_count++;
    endtask

    task automatic write_key(logic [KEY_W-1:0] k);
        s_axis_tvalid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge clk);
        // drain requests that leave no byte
        repeat (10) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we <= 1'b0;
        key_now = k;
    endtask

    task automatic send_request(coef_vec_t masks, logic [COEF_W-1:0] body, logic start,
                                logic typed, logic [BYTE_W-1:0] want);
        logic              bit_in;
        logic [BYTE_W-1:0] exp_byte;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {body, masks};
        s_axis_tuser <= start;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        if (start)
        begin
            held_bits = '0;
            held_count = '0;
        end
        bit_in = decode_cipher_bit(masks, body, key_now);
        if (held_count == 3'd7)
        begin
            exp_byte = typed ? want : {held_bits, bit_in};
            byte_q = {byte_q, exp_byte};
            held_bits = '0;
            held_count = '0;
        end
        else
        begin
            held_bits = {held_bits[PART_W-2:0], bit_in};
            held_count++;
        end
        @(posedge clk);
    endtask

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (byte_q.size() == 0)
                    report_mismatch("plain_byte with no request pending", m_axis_tdata, 8'h00);
                else if (m_axis_tdata !== byte_q[0])
                    report_mismatch("plain_byte", m_axis_tdata, byte_q.pop_front());
                else
                    void'(byte_q.pop_front());
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        coef_vec_t         masks;
        logic [KEY_W-1:0]  next_key;
        logic [COEF_W-1:0] elem;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        key_now = '0;
        held_bits = '0;
        held_count = '0;

        // reset key is zero, so masks drop out until the first load
        cipher_rows = '{
            '{1'b0, 64'h0, 64'h0,                  8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0123_4567_89AB_CDEF, 8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'hFBFA_FFFE_0001_FCFB, 8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd125, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd125, 1'b0, 1'b1, 8'hFF},
            '{1'b0, 64'h0, ONES,                   8'd0,   1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd0,   1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd255, 1'b0, 1'b0, 8'h00},
            // drop the three pending bits
            '{1'b0, 64'h0, 64'h0,                  8'd187, 1'b1, 1'b0, 8'h00},
            // tie decodes as zero
            '{1'b0, 64'h0, ONES,                   8'd188, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd189, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd63,  1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd62,  1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd255, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd251, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd125, 1'b0, 1'b1, 8'h91},
            // start with nothing pending
            '{1'b0, 64'h0, 64'h0,                  8'd125, 1'b1, 1'b0, 8'h00},
            '{1'b1, ONES,  ONES,                   8'd255, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0,                  8'd0,   1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'hFBFB_FBFB_FBFB_FBFB, 8'd250, 1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, 64'h0101_0101_0101_0101, 8'h80,  1'b0, 1'b0, 8'h00},
            '{1'b0, 64'h0, ONES,                   8'd0,   1'b0, 1'b0, 8'h00}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (cipher_rows[i])
        begin
            if (cipher_rows[i].load_key)
                write_key(cipher_rows[i].key);
            send_request(cipher_rows[i].masks, cipher_rows[i].body, cipher_rows[i].start,
                         cipher_rows[i].typed, cipher_rows[i].want);
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            for (int j = 0; j < KEY_LENGTH; j++)
            begin
                case (ph)
                    0: elem = 8'd0;
                    2: elem = 8'($urandom_range(0, 255));
                    3: elem = 8'($urandom_range(MODULUS, 255));
                    4: elem = 8'hFF;
                    default: elem = 8'($urandom_range(0, MODULUS - 1));
                endcase
                next_key[j*COEF_W +: COEF_W] = elem;
            end
            write_key(next_key);
            if (ph == N_PHASES - 1)
                idle_on = 1'b0;
            repeat (PHASE_ITEMS)
            begin
                for (int j = 0; j < KEY_LENGTH; j++)
                    masks[j] = pick_coef();
                send_request(masks, pick_coef(), $urandom_range(0, 19) == 0, 1'b0, 8'h00);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
